@@ rtl/ple_pkg.sv @@
// shared types for the positional list engine: item structs, codes and
// the command that the top level broadcasts along the row of list cells
// no dependencies
package ple_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // command seen by every cell in the same cycle
  typedef enum logic [2:0] {
    CH_HOLD   = 3'd0,
    CH_APPEND = 3'd1,
    CH_INSERT = 3'd2,
    CH_REMOVE = 3'd3,
    CH_ROTATE = 3'd4
  } chain_op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
    logic [3:0]         position;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic [4:0]         entry_count;
    logic               last;
  } out_item_t;

endpackage

@@ rtl/ple_cell.sv @@
// one list cell: holds a single entry and takes a new value from the input,
// its left or right neighbour, or the head of the list
// depends on ple_pkg
module ple_cell
  import ple_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk_i,
  input  chain_op_e          op_i,
  input  logic [CW-1:0]      pos_i,
  input  logic [CW-1:0]      cnt_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] data_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic signed [31:0] data_q, data_d;
  logic [CW-1:0]      cnt_m1;

  assign cnt_m1 = cnt_i - CW'(1);

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      CH_HOLD: data_d = data_q;
      CH_APPEND: begin
        if (IdxC == cnt_i) data_d = value_i;
      end
      CH_INSERT: begin
        if (IdxC == pos_i) data_d = value_i;
        else if (IdxC > pos_i) data_d = left_i;
      end
      CH_REMOVE: begin
        if (IdxC >= pos_i) data_d = right_i;
      end
      CH_ROTATE: begin
        // the tail cell wraps around to the head so a full pass restores the list
        if (IdxC == cnt_m1) data_d = head_i;
        else data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/positional_list_engine.sv @@
// top level of the positional list engine: control, count and output
// register around a row of ple_cell entries
// depends on ple_pkg and ple_cell
//
// An ordered list of up to DEPTH signed 32-bit entries held in a row of
// cells that shift together, so insert and remove move every entry from the
// given position onward in the same cycle. Append, insert and remove each
// give one status item (so does a dump of an empty list): on success the
// accepting edge updates the row, and the status is registered with the new
// tail once the output register is free; no new operation is taken before. A dump
// rotates the row through cell 0 and gives one item per cycle while the
// output register is free; the list is back in place when it ends. The
// input is ready only while no operation is under way and the output
// register is free or being emptied. No clearing is needed after reset.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STAT = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  status_e            status_q, status_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               out_free;
  logic               accept;
  logic [CMPW-1:0]    pos_x, cnt_x;
  logic [CW-1:0]      cnt_m1;
  logic [4:0]         cnt5;
  logic [CW+4:0]      cnt_wide;
  chain_op_e          ch_op;
  logic signed [31:0] tail;
  logic signed [31:0] cell_data [DEPTH];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_x    = CMPW'(in_item_i.position);
  assign cnt_x    = CMPW'(cnt_q);
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_wide = {5'b0, cnt_q};
  assign cnt5     = cnt_wide[4:0];
  assign tail     = (cnt_q == '0) ? 32'sd0 : cell_data[cnt_m1[IW-1:0]];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ch_op       = CH_HOLD;

    if (out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_STAT;
          unique case (in_item_i.operation)
            OP_APPEND: begin
              if (cnt_q >= DepthC) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                ch_op    = CH_APPEND;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (cnt_q >= DepthC) begin
                status_d = ST_FULL;
              end else if (pos_x > cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                status_d = ST_OK;
                ch_op    = CH_INSERT;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                status_d = ST_OK;
                ch_op    = CH_REMOVE;
                cnt_d    = cnt_m1;
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_DUMP;
                idx_d   = '0;
              end
            end
            default: state_d = S_STAT;
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.element     = tail;
          out_d.entry_count = cnt5;
          out_d.last        = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_d.status      = ST_OK;
          out_d.element     = cell_data[0];
          out_d.entry_count = cnt5;
          out_d.last        = (idx_q == cnt_m1);
          out_valid_d       = 1'b1;
          ch_op             = CH_ROTATE;
          idx_d             = idx_q + CW'(1);
          if (idx_q == cnt_m1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    out_q    <= out_d;
  end

  // row of cells, neighbours wired left and right, head fed back for rotation
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = 32'sd0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = 32'sd0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    ple_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (ch_op),
      .pos_i   (pos_x[CW-1:0]),
      .cnt_i   (cnt_q),
      .value_i (in_item_i.value),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
